/* hw/rtl/brtu_pkg.sv */
// ----------------------------------------------------------------------------
// brtu_pkg: shared types and constants of the routing table engine
// Opcodes, status codes, register indexes and the front/back command type.
// ----------------------------------------------------------------------------
package brtu_pkg;

  localparam int unsigned TableDepthDefault = 16;
  localparam logic [7:0]  ThresholdReset    = 8'd100;

  typedef enum logic [1:0] {
    OP_HEADER = 2'd0,
    OP_ENTRY  = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } opcode_t;

  typedef enum logic [3:0] {
    ST_WEAK        = 4'd0,
    ST_SRC_REFRESH = 4'd1,
    ST_SRC_ADDED   = 4'd2,
    ST_SRC_FULL    = 4'd3,
    ST_OWN_SKIP    = 4'd4,
    ST_IMPROVED    = 4'd5,
    ST_KEPT        = 4'd6,
    ST_ADDED       = 4'd7,
    ST_FULL        = 4'd8,
    ST_NO_BEACON   = 4'd9,
    ST_READ_OK     = 4'd10,
    ST_READ_EMPTY  = 4'd11
  } status_t;

  localparam logic REG_NODE_ADDRESS     = 1'b0;
  localparam logic REG_SIGNAL_THRESHOLD = 1'b1;

  // Command handed from the front part to the back part.
  typedef enum logic [1:0] {
    CMD_IMMEDIATE = 2'd0,  // result fully known, no table access
    CMD_HEADER    = 2'd1,  // search for source, refresh or append
    CMD_ENTRY     = 2'd2,  // search for destination, improve or append
    CMD_READ      = 2'd3   // read one slot
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t  kind;
    status_t    status;   // status for immediate results
    logic [7:0] key;      // source or destination
    logic [7:0] via;
    logic [7:0] hops;
    logic [7:0] seq;
    logic [3:0] slot;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SEARCH,
    BK_CHECK,
    BK_UPDATE,
    BK_READ,
    BK_RESULT
  } bk_state_t;

endpackage

/* hw/rtl/beacon_routing_table_update.sv */
// ----------------------------------------------------------------------------
// beacon_routing_table_update: distance-vector routing table engine
// Top level: APB register file, front classifier, command queue, back engine.
// ----------------------------------------------------------------------------
// Items enter on the in_ stream (tuser carries the opcode, tdata the other
// fields) and every item yields exactly one result transfer on the out_
// stream. Registers node_address (0x0) and signal_threshold (0x4) sit on
// the APB cfg_ port and must be written only while the block is idle.
// The front part classifies each item in the cycle it is accepted and
// tracks the open beacon; a two-entry queue feeds the back part, which
// scans the table one slot per cycle through the table RAM's single port.
// A header or entry item is compared against the valid slots in order and
// then updated or appended, a read item reads its one slot, and a rejected
// or ignored item goes straight to the result.
// Reset empties the table (entry count zero), closes the beacon and loads
// the register defaults; no clearing pass is needed. When the receiver
// stalls, the result holds on out_ and the queue takes up to two more
// items before in_tready falls.
// ----------------------------------------------------------------------------
module beacon_routing_table_update
  import brtu_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = TableDepthDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // tdata: source address, beacon sequence, signal level,
  //        route_destination, route_hops, read_slot (lowest first)
  input  logic [47:0] in_tdata,
  // tuser: opcode
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // tdata: status, slot, entry_count, destination, via node,
  //        hops, sequence (lowest first)
  output logic [47:0] out_tdata,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [7:0] node_addr_r, thresh_r;
  logic       fq_valid, fq_ready, qb_valid, qb_ready;
  cmd_t       fq_cmd, qb_cmd;
  logic [3:0] status, slot;
  logic [4:0] entry_count;
  logic [7:0] r_dest, r_nh, r_hops, r_seq;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_addr_r <= 8'd0;
      thresh_r    <= ThresholdReset;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      if (cfg_paddr[2] == REG_NODE_ADDRESS)     node_addr_r <= cfg_pwdata[7:0];
      if (cfg_paddr[2] == REG_SIGNAL_THRESHOLD) thresh_r    <= cfg_pwdata[7:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_SIGNAL_THRESHOLD) ? {24'd0, thresh_r}
                                                              : {24'd0, node_addr_r};

  brtu_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_tvalid),
    .in_ready          (in_tready),
    .opcode            (in_tuser),
    .src_addr          (in_tdata[7:0]),
    .seq_num           (in_tdata[15:8]),
    .rssi              (in_tdata[23:16]),
    .route_destination (in_tdata[31:24]),
    .route_hops        (in_tdata[39:32]),
    .read_slot         (in_tdata[43:40]),
    .node_address      (node_addr_r),
    .signal_threshold  (thresh_r),
    .q_ready           (fq_ready),
    .q_valid           (fq_valid),
    .q_cmd             (fq_cmd)
  );

  brtu_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fq_valid),
    .wr_ready (fq_ready),
    .wr_cmd   (fq_cmd),
    .rd_valid (qb_valid),
    .rd_ready (qb_ready),
    .rd_cmd   (qb_cmd)
  );

  brtu_back #(.TableDepth(TABLE_DEPTH)) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (qb_valid),
    .cmd_ready    (qb_ready),
    .cmd          (qb_cmd),
    .res_valid    (out_tvalid),
    .res_ready    (out_tready),
    .status       (status),
    .slot         (slot),
    .entry_count  (entry_count),
    .res_dest     (r_dest),
    .res_via      (r_nh),
    .res_hops     (r_hops),
    .res_seq      (r_seq)
  );

  assign out_tdata = {3'd0, r_seq, r_hops, r_nh, r_dest, entry_count, slot, status};

endmodule

/* hw/rtl/brtu_ram.sv */
// ----------------------------------------------------------------------------
// brtu_ram: generic single-port RAM with registered read
// One write or one read a cycle.
// ----------------------------------------------------------------------------
module brtu_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] addr,
  input  logic [Width-1:0]                             wdata,
  output logic [Width-1:0]                             rdata
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/brtu_front.sv */
// ----------------------------------------------------------------------------
// brtu_front: item intake and classification
// Holds the beacon state and turns each item into a command for the back part.
// ----------------------------------------------------------------------------
module brtu_front
  import brtu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  logic [7:0] src_addr,
  input  logic [7:0] seq_num,
  input  logic [7:0] rssi,
  input  logic [7:0] route_destination,
  input  logic [7:0] route_hops,
  input  logic [3:0] read_slot,
  input  logic [7:0] node_address,
  input  logic [7:0] signal_threshold,
  input  logic       q_ready,
  output logic       q_valid,
  output cmd_t       q_cmd
);

  logic       beacon_open_r, beacon_open_nxt;
  logic [7:0] cur_src_r, cur_src_nxt;
  logic [7:0] cur_seq_r, cur_seq_nxt;
  logic [7:0] hops_inc;

  assign in_ready = q_ready;
  assign q_valid  = in_valid;
  assign hops_inc = (route_hops == 8'hFF) ? 8'hFF : route_hops + 8'd1;

  always_comb begin
    beacon_open_nxt = beacon_open_r;
    cur_src_nxt     = cur_src_r;
    cur_seq_nxt     = cur_seq_r;
    q_cmd           = '0;
    q_cmd.slot      = read_slot;
    case (opcode_t'(opcode))
      OP_HEADER: begin
        if (rssi < signal_threshold) begin
          beacon_open_nxt = 1'b0;
          q_cmd.kind      = CMD_IMMEDIATE;
          q_cmd.status    = ST_WEAK;
        end else begin
          beacon_open_nxt = 1'b1;
          cur_src_nxt     = src_addr;
          cur_seq_nxt     = seq_num;
          q_cmd.kind      = CMD_HEADER;
          q_cmd.key       = src_addr;
          q_cmd.via       = src_addr;
          q_cmd.hops      = 8'd1;
          q_cmd.seq       = seq_num;
        end
      end
      OP_ENTRY: begin
        if (!beacon_open_r) begin
          q_cmd.kind   = CMD_IMMEDIATE;
          q_cmd.status = ST_NO_BEACON;
        end else if (route_destination == node_address) begin
          q_cmd.kind   = CMD_IMMEDIATE;
          q_cmd.status = ST_OWN_SKIP;
        end else begin
          q_cmd.kind     = CMD_ENTRY;
          q_cmd.key      = route_destination;
          q_cmd.via      = cur_src_r;
          q_cmd.hops     = hops_inc;
          q_cmd.seq      = cur_seq_r;
        end
      end
      OP_READ: begin
        q_cmd.kind = CMD_READ;
      end
      default: begin
        q_cmd.kind   = CMD_IMMEDIATE;
        q_cmd.status = ST_READ_EMPTY;
        q_cmd.slot   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      beacon_open_r <= 1'b0;
      cur_src_r     <= '0;
      cur_seq_r     <= '0;
    end else if (in_valid && q_ready) begin
      beacon_open_r <= beacon_open_nxt;
      cur_src_r     <= cur_src_nxt;
      cur_seq_r     <= cur_seq_nxt;
    end
  end

endmodule

/* hw/rtl/brtu_queue.sv */
// ----------------------------------------------------------------------------
// brtu_queue: two-entry command queue between front and back
// Lets the front part take the next item while the back part is busy.
// ----------------------------------------------------------------------------
module brtu_queue
  import brtu_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_cmd,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_cmd
);

  cmd_t       buf_r [2];
  logic       wptr_r, rptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_cmd   = buf_r[rptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wptr_r] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) wptr_r <= ~wptr_r;
      if (pop)  rptr_r <= ~rptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

/* hw/rtl/brtu_back.sv */
// ----------------------------------------------------------------------------
// brtu_back: table search and update engine
// Scans the slots one per cycle, updates the table and presents the result.
// ----------------------------------------------------------------------------
module brtu_back
  import brtu_pkg::*;
#(
  parameter int unsigned TableDepth = TableDepthDefault
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  output logic       res_valid,
  input  logic       res_ready,
  output logic [3:0] status,
  output logic [3:0] slot,
  output logic [4:0] entry_count,
  output logic [7:0] res_dest,
  output logic [7:0] res_via,
  output logic [7:0] res_hops,
  output logic [7:0] res_seq
);

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);

  bk_state_t       state_r, state_nxt;
  cmd_t            cmd_r, cmd_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  status_t         st_r, st_nxt;
  logic            with_slot_r, with_slot_nxt;
  logic [AW-1:0]   hit_r, hit_nxt;

  logic          we;
  logic [AW-1:0] addr;
  logic [31:0]   wdata, rdata;
  logic [31:0]   word_r, word_nxt;
  logic          busy_rd_r, busy_rd_nxt;  // rdata valid for slot idx_r-1

  // One word per slot: {seq, hops, via, dest}.
  brtu_ram #(.Width(32), .Depth(TableDepth)) u_table (
    .clk   (clk),
    .we    (we),
    .addr  (addr),
    .wdata (wdata),
    .rdata (rdata)
  );

  assign cmd_ready = (state_r == BK_IDLE);
  assign res_valid = (state_r == BK_RESULT);
  assign status      = st_r;
  assign entry_count = 5'(count_r);
  assign slot        = (with_slot_r || st_r == ST_READ_EMPTY) ? 4'(cmd_r.slot) : 4'd0;
  assign res_dest     = with_slot_r ? word_r[7:0]   : 8'd0;
  assign res_via      = with_slot_r ? word_r[15:8]  : 8'd0;
  assign res_hops     = with_slot_r ? word_r[23:16] : 8'd0;
  assign res_seq      = with_slot_r ? word_r[31:24] : 8'd0;

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    st_nxt        = st_r;
    with_slot_nxt = with_slot_r;
    hit_nxt       = hit_r;
    word_nxt      = word_r;
    busy_rd_nxt   = 1'b0;
    we            = 1'b0;
    addr          = idx_r[AW-1:0];
    wdata         = word_r;
    case (state_r)
      BK_IDLE: begin
        if (cmd_valid) begin
          cmd_nxt       = cmd;
          idx_nxt       = '0;
          with_slot_nxt = 1'b0;
          st_nxt        = cmd.status;
          case (cmd.kind)
            CMD_IMMEDIATE: state_nxt = BK_RESULT;
            CMD_READ: begin
              if (32'(cmd.slot) < 32'(count_r)) begin
                state_nxt = BK_READ;
              end else begin
                st_nxt    = ST_READ_EMPTY;
                state_nxt = BK_RESULT;
              end
            end
            default: state_nxt = BK_SEARCH;
          endcase
        end
      end
      BK_SEARCH: begin
        // Issue read for slot idx_r; compare the word read last cycle.
        if (busy_rd_r && rdata[7:0] == cmd_r.key) begin
          hit_nxt   = AW'(idx_r - CW'(1));
          word_nxt  = rdata;
          state_nxt = BK_CHECK;
        end else if (idx_r >= count_r) begin
          hit_nxt   = AW'(count_r);
          state_nxt = BK_UPDATE;
          with_slot_nxt = 1'b0;
          word_nxt  = 32'hFFFF_FFFF;  // marks miss
        end else begin
          addr        = idx_r[AW-1:0];
          idx_nxt     = idx_r + CW'(1);
          busy_rd_nxt = 1'b1;
        end
        if (state_nxt == BK_CHECK) with_slot_nxt = 1'b1;
      end
      BK_CHECK: begin
        // Hit: update the found slot in place, or keep it when the route is no shorter.
        addr = hit_r;
        cmd_nxt.slot = 4'(hit_r);
        if (cmd_r.kind == CMD_HEADER) begin
          word_nxt  = {cmd_r.seq, word_r[23:0]};
          we        = 1'b1;
          wdata     = {cmd_r.seq, word_r[23:0]};
          st_nxt    = ST_SRC_REFRESH;
        end else if (cmd_r.hops < word_r[23:16]) begin
          word_nxt  = {word_r[31:24], cmd_r.hops, cmd_r.via, word_r[7:0]};
          we        = 1'b1;
          wdata     = word_nxt;
          st_nxt    = ST_IMPROVED;
        end else begin
          st_nxt    = ST_KEPT;
        end
        state_nxt = BK_RESULT;
      end
      BK_UPDATE: begin
        // Miss: append if room remains.
        addr = hit_r;
        if (count_r < CW'(TableDepth)) begin
          word_nxt      = {cmd_r.seq, cmd_r.hops, cmd_r.via, cmd_r.key};
          we            = 1'b1;
          wdata         = word_nxt;
          with_slot_nxt = 1'b1;
          cmd_nxt.slot  = 4'(count_r);
          count_nxt     = count_r + CW'(1);
          st_nxt        = (cmd_r.kind == CMD_HEADER) ? ST_SRC_ADDED : ST_ADDED;
        end else begin
          with_slot_nxt = 1'b0;
          cmd_nxt.slot  = '0;
          st_nxt        = (cmd_r.kind == CMD_HEADER) ? ST_SRC_FULL : ST_FULL;
        end
        state_nxt = BK_RESULT;
      end
      BK_READ: begin
        addr = AW'(cmd_r.slot);
        if (busy_rd_r) begin
          word_nxt      = rdata;
          with_slot_nxt = 1'b1;
          st_nxt        = ST_READ_OK;
          state_nxt     = BK_RESULT;
        end else begin
          busy_rd_nxt = 1'b1;
        end
      end
      BK_RESULT: begin
        if (res_ready) state_nxt = BK_IDLE;
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BK_IDLE;
      count_r   <= '0;
      busy_rd_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      busy_rd_r <= busy_rd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    idx_r       <= idx_nxt;
    st_r        <= st_nxt;
    with_slot_r <= with_slot_nxt;
    hit_r       <= hit_nxt;
    word_r      <= word_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(TableDepth)) else $error("entry count past table depth");
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |-> $past(state_r) == BK_UPDATE)
    else $error("entry count moved outside append");
  a_write_ctx: assert property (@(posedge clk) disable iff (!rst_n)
    we |-> (state_r == BK_CHECK || state_r == BK_UPDATE))
    else $error("table write outside update states");

endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench of the routing table engine
// Beacon headers, route entries and slot reads are streamed in with random
// gaps. A table predictor computes the result of each transfer, and every
// transfer on the result stream is checked field by field.
// ----------------------------------------------------------------------------
module tb;
  import brtu_pkg::*;

  localparam int Depth = 16;

  typedef struct packed {
    opcode_t    op;
    logic [7:0] src;
    logic [7:0] seq;
    logic [7:0] sig;
    logic [7:0] dst;
    logic [7:0] adv;
    logic [3:0] rslot;
  } beacon_item_t;

  // Highest field first, so status lands in the lowest bits of tdata.
  typedef struct packed {
    logic [7:0] seq;
    logic [7:0] hops;
    logic [7:0] nhop;
    logic [7:0] dest;
    logic [4:0] count;
    logic [3:0] slot;
    status_t    status;
  } table_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  beacon_routing_table_update u_dut (.*);

  // Predictor state.
  logic [7:0]  own_addr;
  logic [7:0]  threshold;
  logic [7:0]  tbl_dest [Depth];
  logic [7:0]  tbl_nhop [Depth];
  logic [7:0]  tbl_hops [Depth];
  logic [7:0]  tbl_seq  [Depth];
  int          entries;
  bit          open_beacon;
  logic [7:0]  cur_src;
  logic [7:0]  cur_seq;

  beacon_item_t  pending_items[$];
  table_result_t expected_results[$];
  int            error_count;
  int            result_count;
  int            status_seen[12];
  bit            send_idle_en;
  bit            recv_idle_en;
  bit            recv_hold;
  bit            in_taken;
  int            send_gap;
  int            recv_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    error_count++;
    $display("mismatch at result %0d: %s got %0d expected %0d",
             result_count, what, got, want);
  endtask

  function automatic int find_slot(input logic [7:0] key);
    for (int i = 0; i < entries; i++) begin
      if (tbl_dest[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic table_result_t slot_result(input status_t st, input int s);
    table_result_t r;
    r = '0;
    r.status = st;
    r.count = entries[4:0];
    if (s >= 0) begin
      r.slot = s[3:0];
      r.dest = tbl_dest[s];
      r.nhop = tbl_nhop[s];
      r.hops = tbl_hops[s];
      r.seq = tbl_seq[s];
    end
    return r;
  endfunction

  function automatic table_result_t update_table(input beacon_item_t it);
    int         s;
    logic [7:0] nh;
    table_result_t r;
    case (it.op)
      OP_HEADER: begin
        if (it.sig < threshold) begin
          open_beacon = 0;
          return slot_result(ST_WEAK, -1);
        end
        open_beacon = 1;
        cur_src = it.src;
        cur_seq = it.seq;
        s = find_slot(it.src);
        if (s >= 0) begin
          tbl_seq[s] = it.seq;
          return slot_result(ST_SRC_REFRESH, s);
        end
        if (entries < Depth) begin
          s = entries;
          tbl_dest[s] = it.src;
          tbl_nhop[s] = it.src;
          tbl_hops[s] = 8'd1;
          tbl_seq[s] = it.seq;
          entries++;
          return slot_result(ST_SRC_ADDED, s);
        end
        return slot_result(ST_SRC_FULL, -1);
      end
      OP_ENTRY: begin
        if (!open_beacon) return slot_result(ST_NO_BEACON, -1);
        if (it.dst == own_addr) return slot_result(ST_OWN_SKIP, -1);
        nh = (it.adv == 8'hff) ? 8'hff : it.adv + 8'd1;
        s = find_slot(it.dst);
        if (s >= 0) begin
          if (nh < tbl_hops[s]) begin
            tbl_hops[s] = nh;
            tbl_nhop[s] = cur_src;
            return slot_result(ST_IMPROVED, s);
          end
          return slot_result(ST_KEPT, s);
        end
        if (entries < Depth) begin
          s = entries;
          tbl_dest[s] = it.dst;
          tbl_nhop[s] = cur_src;
          tbl_hops[s] = nh;
          tbl_seq[s] = cur_seq;
          entries++;
          return slot_result(ST_ADDED, s);
        end
        return slot_result(ST_FULL, -1);
      end
      OP_READ: begin
        if (it.rslot < entries) return slot_result(ST_READ_OK, it.rslot);
        r = slot_result(ST_READ_EMPTY, -1);
        r.slot = it.rslot;
        return r;
      end
      default: return slot_result(ST_READ_EMPTY, -1);
    endcase
  endfunction

  // Driver: predicts at the accepting edge, presents the next item at the
  // falling edge after it.
  always @(posedge clk) begin
    in_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      expected_results.push_back(update_table(pending_items.pop_front()));
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_taken) begin
      // hold the current item
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      in_tvalid <= 1'b0;
    end else if (send_idle_en && $urandom_range(0, 9) == 0) begin
      send_gap <= $urandom_range(1, 14) - 1;
      in_tvalid <= 1'b0;
    end else if (pending_items.size() > 0) begin
      in_tvalid <= 1'b1;
      in_tuser <= pending_items[0].op;
      in_tdata <= {4'd0, pending_items[0].rslot, pending_items[0].adv,
                   pending_items[0].dst, pending_items[0].sig, pending_items[0].seq,
                   pending_items[0].src};
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // Monitor and checker.
  always @(posedge clk) begin
    table_result_t got;
    table_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[44:0];
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected transfer, status", 8'(got.status), 8'd0);
      end else begin
        want = expected_results.pop_front();
        if (got.status != want.status)
          report_mismatch("status", 8'(got.status), 8'(want.status));
        if (got.slot != want.slot) report_mismatch("slot", 8'(got.slot), 8'(want.slot));
        if (got.count != want.count)
          report_mismatch("entry_count", 8'(got.count), 8'(want.count));
        if (got.dest != want.dest) report_mismatch("destination", got.dest, want.dest);
        if (got.nhop != want.nhop) report_mismatch("via node", got.nhop, want.nhop);
        if (got.hops != want.hops) report_mismatch("hops", got.hops, want.hops);
        if (got.seq != want.seq) report_mismatch("sequence", got.seq, want.seq);
        if (want.status <= ST_READ_EMPTY) status_seen[want.status]++;
      end
      result_count++;
    end
  end

  always @(negedge clk) begin
    if (!rst_n || recv_hold) begin
      out_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_tready <= 1'b0;
    end else if (recv_idle_en && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(1, 14) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(input logic [2:0] addr, input logic [7:0] value);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= {24'd0, value};
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (addr == 3'd0) own_addr = value;
    else threshold = value;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic wait_drained();
    int guard;
    guard = 0;
    while ((pending_items.size() > 0 || in_tvalid || expected_results.size() > 0)
           && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (30) @(posedge clk);
  endtask

  task automatic push_item(input opcode_t op, input logic [7:0] src, input logic [7:0] seq,
                           input logic [7:0] sig, input logic [7:0] dst,
                           input logic [7:0] adv, input logic [3:0] rslot);
    pending_items.push_back('{op, src, seq, sig, dst, adv, rslot});
  endtask

  // A beacon from a small neighbour set with random routes keeps lookups
  // hitting existing slots while the table grows and then stays full.
  task automatic push_beacon(input logic [7:0] lo, input logic [7:0] hi);
    int n;
    push_item(OP_HEADER, 8'($urandom_range(lo, hi)), 8'($urandom),
              8'($urandom_range(60, 255)), 8'($urandom), 8'($urandom), 4'($urandom));
    n = $urandom_range(0, 6);
    repeat (n) begin
      push_item(OP_ENTRY, 8'($urandom), 8'($urandom), 8'($urandom),
                ($urandom_range(0, 7) == 0) ? own_addr : 8'($urandom_range(lo, hi)),
                ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12)),
                4'($urandom));
    end
  endtask

  task automatic push_noise();
    logic [1:0] op;
    op = 2'($urandom_range(0, 3));
    // reads only reach slots that have been written
    push_item(opcode_t'(op), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom),
              (op == OP_NONE) ? 4'($urandom)
                              : 4'($urandom_range(0, (entries > 0) ? entries - 1 : 0)));
  endtask

  initial begin
    int hold_cycles;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    send_gap = 0;
    recv_gap = 0;
    send_idle_en = 1;
    recv_idle_en = 1;
    recv_hold = 0;
    error_count = 0;
    result_count = 0;
    own_addr = 8'd0;
    threshold = ThresholdReset;
    entries = 0;
    open_beacon = 0;
    cur_src = '0;
    cur_seq = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part at reset defaults: empty reads, entry with no beacon,
    // weak and strong headers, own address skip, saturation, keep and refresh.
    push_item(OP_READ, 0, 0, 0, 0, 0, 4'hf);
    push_item(OP_NONE, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 4'hf);
    push_item(OP_ENTRY, 0, 0, 0, 8'd5, 8'd3, 0);
    push_item(OP_HEADER, 8'd7, 8'd1, 8'd99, 0, 0, 0);
    push_item(OP_HEADER, 8'd7, 8'd2, 8'd100, 0, 0, 0);
    push_item(OP_ENTRY, 0, 0, 0, 8'd0, 8'd3, 0);
    push_item(OP_ENTRY, 0, 0, 0, 8'hff, 8'hff, 0);
    push_item(OP_ENTRY, 0, 0, 0, 8'hff, 8'hfe, 0);
    push_item(OP_ENTRY, 0, 0, 0, 8'hff, 8'hfe, 0);
    push_item(OP_ENTRY, 0, 0, 0, 8'd7, 8'd0, 0);
    push_item(OP_HEADER, 8'd7, 8'hff, 8'hff, 0, 0, 0);
    push_item(OP_READ, 0, 0, 0, 0, 0, 4'd1);
    push_item(OP_HEADER, 8'd9, 8'd3, 8'd0, 0, 0, 0);
    push_item(OP_ENTRY, 0, 0, 0, 8'd5, 8'd3, 0);
    wait_drained();

    // Fill the table to its end with node address and threshold at extremes.
    write_reg(3'd0, 8'hff);
    write_reg(3'd4, 8'hff);
    push_item(OP_HEADER, 8'd0, 8'h55, 8'hfe, 0, 0, 0);
    push_item(OP_HEADER, 8'd0, 8'haa, 8'hff, 0, 0, 0);
    for (int i = 0; i < 16; i++) push_item(OP_ENTRY, 0, 0, 0, 8'(100 + i), 8'($urandom), 0);
    push_item(OP_ENTRY, 0, 0, 0, 8'hff, 8'd1, 0);
    push_item(OP_HEADER, 8'd200, 8'd1, 8'hff, 0, 0, 0);
    push_item(OP_ENTRY, 0, 0, 0, 8'd201, 8'd1, 0);
    push_item(OP_READ, 0, 0, 0, 0, 0, 4'd15);
    wait_drained();

    // Reopen with a fresh threshold and node address: the table stays full,
    // so random beacons now exercise refresh, improve and keep.
    write_reg(3'd4, 8'd0);
    write_reg(3'd0, 8'd102);
    for (int k = 0; k < 120; k++) begin
      if ($urandom_range(0, 3) == 0) push_noise();
      else push_beacon(8'd95, 8'd120);
    end

    // Long receiver stall with the sender still offering items.
    wait (pending_items.size() > 0 && in_tvalid);
    recv_hold = 1;
    hold_cycles = 0;
    while (hold_cycles < 300) begin
      @(posedge clk);
      hold_cycles++;
    end
    recv_hold = 0;
    wait_drained();

    // Sender pauses until everything is back, then the last stretch runs
    // without idling on either side.
    write_reg(3'd4, 8'd128);
    write_reg(3'd0, 8'd0);
    send_idle_en = 0;
    recv_idle_en = 0;
    for (int k = 0; k < 40; k++) begin
      if ($urandom_range(0, 3) == 0) push_noise();
      else push_beacon(8'd90, 8'd130);
    end
    wait_drained();

    $display("results checked: %0d; weak %0d refreshed %0d improved %0d kept %0d full %0d",
             result_count, status_seen[ST_WEAK], status_seen[ST_SRC_REFRESH],
             status_seen[ST_IMPROVED], status_seen[ST_KEPT], status_seen[ST_FULL]);
    $display("added %0d skips %0d no-beacon %0d reads %0d/%0d", status_seen[ST_ADDED],
             status_seen[ST_OWN_SKIP], status_seen[ST_NO_BEACON],
             status_seen[ST_READ_OK], status_seen[ST_READ_EMPTY]);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
